// ===== rtl/cke_pkg.sv =====
`default_nettype none

package cke_pkg;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_CONVERT = 2'd2
  } cmd_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_KEY    = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // source formats
  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_ARGB1555 = 1'b1;

  // alpha values
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_HALF   = 8'h80;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // classified item handed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic        keyed;
    logic [31:0] pixel;
  } op_t;

  // valid flag on the queue ports
  typedef struct packed {
    logic valid;
  } hs_t;

endpackage

`default_nettype wire

// ===== rtl/chroma_key_texel_expander_top.sv =====
// Chroma-key texel expander: 16-bit RGB565 or ARGB1555 texels to RGBA8888.
// Input stream: s_axis_tdata carries the texel, s_axis_tuser the command
// (begin texture, scan texel for seed, convert texel; code 3 is dropped).
// Output stream: one item per convert command, m_axis_tdata the pixel
// (R in 31:24, alpha in 7:0), m_axis_tuser set when the texel matched the
// key and the replacement color was sent.
// Config channel: index 0 selects the source format, index 1 the chroma
// key; always ready, write only while the stream is idle.
// Throughput: one item per cycle sustained while the receiver does not stall. A convert
// item is written into the queue, then into the output register.
// The front classifies items (key compare, expansion) and writes them into
// a two-entry queue; the back pops one per cycle unless a convert waits on a stalled
// output, keeps the replacement color and seed flag, and drives a single output register.
// Reset: queue and output emptied, registers, replacement color and seed
// flag cleared.
// When the receiver stalls the output register holds; begin and scan items
// still drain, and the input stalls once the queue is full.
`default_nettype none

module chroma_key_texel_expander_top
  import cke_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,  // texel[15:0]
  input  wire logic [1:0]            s_axis_tuser,  // command[1:0]
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // color[31:0]
  output logic                       m_axis_tuser   // was_keyed
);

  hs_t  push_hs;
  logic push_ready;
  op_t  push_op;
  hs_t  pop_hs;
  logic pop;
  op_t  pop_op;

  cke_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_texel_i   (s_axis_tdata),
    .push_o       (push_hs),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  cke_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_hs),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_o        (pop_hs),
    .pop_i        (pop),
    .pop_op_o     (pop_op)
  );

  cke_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop_hs),
    .pop_o       (pop),
    .pop_op_i    (pop_op),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_color_o (m_axis_tdata),
    .out_keyed_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/cke_front.sv =====
`default_nettype none

module cke_front
  import cke_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // incoming texel items
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            in_cmd_i,
  input  wire logic [15:0]           in_texel_i,
  // classified items toward the queue
  output hs_t                        push_o,
  input  wire logic                  push_ready_i,
  output op_t                        push_op_o
);

  logic        format_q;
  logic [15:0] key_q;
  logic        keyed;
  logic [31:0] pixel;
  cmd_e        cmd;
  logic        cmd_known;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_RGB565;
      key_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOURCE_FORMAT: format_q <= cfg_data_i[0];
        CFG_CHROMA_KEY:    key_q    <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // key compare, alpha bit masked in 1555 mode
  always_comb begin
    if (format_q == FMT_ARGB1555) begin
      keyed = (in_texel_i[14:0] == key_q[14:0]);
    end else begin
      keyed = (in_texel_i == key_q);
    end
  end

  // expansion without bit replication
  always_comb begin
    if (format_q == FMT_ARGB1555) begin
      pixel = {in_texel_i[14:10], 3'b000, in_texel_i[9:5], 3'b000,
               in_texel_i[4:0], 3'b000,
               (in_texel_i[15] ? ALPHA_OPAQUE : ALPHA_HALF)};
    end else begin
      pixel = {in_texel_i[15:11], 3'b000, in_texel_i[10:5], 2'b00,
               in_texel_i[4:0], 3'b000, ALPHA_OPAQUE};
    end
  end

  // unused command code is dropped here
  always_comb begin
    cmd       = CMD_BEGIN;
    cmd_known = 1'b1;
    case (in_cmd_i)
      CMD_BEGIN:   cmd = CMD_BEGIN;
      CMD_SCAN:    cmd = CMD_SCAN;
      CMD_CONVERT: cmd = CMD_CONVERT;
      default:     cmd_known = 1'b0;
    endcase
  end

  assign in_ready_o      = push_ready_i;
  assign push_o.valid    = in_valid_i && cmd_known;
  assign push_op_o.cmd   = cmd;
  assign push_op_o.keyed = keyed;
  assign push_op_o.pixel = pixel;

endmodule

`default_nettype wire

// ===== rtl/cke_queue.sv =====
`default_nettype none

module cke_queue
  import cke_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire hs_t  push_i,
  output logic      push_ready_o,
  input  wire op_t  push_op_i,
  output hs_t       pop_o,
  input  wire logic pop_i,
  output op_t       pop_op_o
);

  op_t                    mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && (count_q != '0);

  assign pop_o.valid = (count_q != '0);
  assign pop_op_o    = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cke_back.sv =====
`default_nettype none

module cke_back
  import cke_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  // items from the queue
  input  wire hs_t    pop_i,
  output logic        pop_o,
  input  wire op_t    pop_op_i,
  // result items
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [31:0] out_color_o,
  output logic        out_keyed_o
);

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_color_q, out_color_d;
  logic        out_keyed_q, out_keyed_d;
  logic [23:0] repl_q, repl_d;
  logic        seed_q, seed_d;
  logic        slot_free;
  logic        is_convert;
  logic        take;

  // output register frees when empty or being drained
  assign slot_free  = !out_valid_q || out_ready_i;
  assign is_convert = (pop_op_i.cmd == CMD_CONVERT);
  assign take       = pop_i.valid && (slot_free || !is_convert);
  assign pop_o      = take;

  // state update and result formation
  always_comb begin
    repl_d      = repl_q;
    seed_d      = seed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_color_d = out_color_q;
    out_keyed_d = out_keyed_q;
    if (take) begin
      case (pop_op_i.cmd)
        CMD_BEGIN: begin
          repl_d = '0;
          seed_d = 1'b0;
        end
        CMD_SCAN: begin
          if (!seed_q) begin
            repl_d = pop_op_i.pixel[31:8];
            seed_d = !pop_op_i.keyed;
          end
        end
        CMD_CONVERT: begin
          out_valid_d = 1'b1;
          out_keyed_d = pop_op_i.keyed;
          if (pop_op_i.keyed) begin
            out_color_d = {repl_q, ALPHA_CLEAR};
          end else begin
            out_color_d = pop_op_i.pixel;
            repl_d      = pop_op_i.pixel[31:8];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      repl_q      <= '0;
      seed_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      repl_q      <= repl_d;
      seed_q      <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_color_q <= out_color_d;
    out_keyed_q <= out_keyed_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_color_o = out_color_q;
  assign out_keyed_o = out_keyed_q;

endmodule

`default_nettype wire

// ===== rtl/cke_checker.sv =====
`default_nettype none

module cke_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // a stalled result item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // a stalled result item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // replacement colors are always fully transparent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("keyed pixel with nonzero alpha");

  // expanded texels are opaque or half alpha
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[7:0] == 8'hff || m_axis_tdata[7:0] == 8'h80)
    else $error("unkeyed pixel with bad alpha");

  // no bit replication: low bits of each color byte stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[26:24] == 3'b000 &&
      m_axis_tdata[17:16] == 2'b00 && m_axis_tdata[10:8] == 3'b000)
    else $error("nonzero low color bits");

endmodule

bind chroma_key_texel_expander_top cke_checker u_cke_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cke_pkg::*;

  // command value that the block drops
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] texel;
  } texel_item_t;

  typedef struct packed {
    logic [31:0] color;
    logic        keyed;
  } pixel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SOURCE_FORMAT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_BEGIN;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  // stimulus and expected pixels
  texel_item_t   texel_q[$];
  pixel_result_t pixel_q[$];
  texel_item_t   drv_item;

  // predictor copy of registers and state
  logic        fmt_1555 = FMT_RGB565;
  logic [15:0] key_val = '0;
  logic [31:0] fill_color = '0;
  logic        seed_done = 1'b0;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  logic        src_idle_en = 1'b1;
  logic        snk_idle_en = 1'b1;
  logic        in_taken = 1'b0;

  chroma_key_texel_expander_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // texel expansion, no bit replication
  function automatic logic [31:0] expand_texel(logic [15:0] t);
    if (fmt_1555 == FMT_ARGB1555)
      return {t[14:10], 3'b0, t[9:5], 3'b0, t[4:0], 3'b0,
              t[15] ? ALPHA_OPAQUE : ALPHA_HALF};
    return {t[15:11], 3'b0, t[10:5], 2'b0, t[4:0], 3'b0, ALPHA_OPAQUE};
  endfunction

  function automatic logic texel_is_key(logic [15:0] t);
    if (fmt_1555 == FMT_ARGB1555)
      return t[14:0] == key_val[14:0];
    return t == key_val;
  endfunction

  // update replacement color and seed, queue the pixel a convert produces
  task automatic predict_pixel(texel_item_t it);
    logic          keyed;
    logic [31:0]   px;
    pixel_result_t res;
    keyed = texel_is_key(it.texel);
    px = expand_texel(it.texel);
    case (it.cmd)
      CMD_BEGIN: begin
        fill_color = '0;
        seed_done = 1'b0;
      end
      CMD_SCAN: begin
        if (!seed_done) begin
          fill_color = {px[31:8], ALPHA_CLEAR};
          if (!keyed) seed_done = 1'b1;
        end
      end
      CMD_CONVERT: begin
        if (keyed) begin
          res.color = fill_color;
          res.keyed = 1'b1;
        end else begin
          fill_color = {px[31:8], ALPHA_CLEAR};
          res.color = px;
          res.keyed = 1'b0;
        end
        pixel_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // texel driver
  always @(negedge clk_i) begin
    if (s_axis_tvalid && !in_taken) begin
      // hold until taken
    end else if (src_gap != 0) begin
      src_gap <= src_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (texel_q.size() != 0) begin
      drv_item = texel_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= drv_item.texel;
      s_axis_tuser <= drv_item.cmd;
      src_gap <= src_idle_en ? pick_gap() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // pixel receiver stalls
  always @(negedge clk_i) begin
    if (snk_gap != 0) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      snk_gap <= snk_idle_en ? pick_gap() : 0;
    end
  end

  // monitor: register writes, accepted texels, received pixels
  always @(posedge clk_i) begin
    pixel_result_t want;
    cycles <= cycles + 1;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SOURCE_FORMAT) fmt_1555 = cfg_data_i[0];
        else key_val = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_pixel('{cmd: s_axis_tuser, texel: s_axis_tdata});
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected pixel: color %h keyed %b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = pixel_q.pop_front();
          if (want.color !== m_axis_tdata || want.keyed !== m_axis_tuser) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("pixel mismatch: expected color %h keyed %b, got color %h keyed %b",
                       want.color, want.keyed, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push(logic [1:0] cmd, logic [15:0] texel);
    texel_q.push_back('{cmd: cmd, texel: texel});
  endtask

  // wait until every item is taken and every pixel has come back
  task automatic drain();
    do @(posedge clk_i);
    while (texel_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // texel that matches the key; in 1555 mode the alpha bit is free
  function automatic logic [15:0] key_texel();
    logic [15:0] t;
    t = key_val;
    if (fmt_1555 == FMT_ARGB1555) t[15] = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // one texture: begin (not always), seed scans, converts, with some noise
  task automatic push_texture(output int unsigned n);
    int unsigned scans;
    int unsigned convs;
    int unsigned r;
    n = 0;
    if ($urandom_range(0, 9) != 0) begin
      push(CMD_BEGIN, 16'($urandom));
      n++;
    end
    scans = $urandom_range(0, 4);
    for (int i = 0; i < scans; i++) begin
      push(CMD_SCAN, ($urandom_range(0, 2) == 0) ? key_texel() : 16'($urandom));
      n++;
    end
    convs = $urandom_range(2, 16);
    for (int i = 0; i < convs; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) push(CMD_CONVERT, key_texel());
      else if (r < 88) push(CMD_CONVERT, 16'($urandom));
      else if (r < 94) push(CMD_SCAN, 16'($urandom));
      else push(2'($urandom_range(0, 3)), 16'($urandom));
      n++;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned in_phase;
    int unsigned n;
    int unsigned phase;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 565, key zero
    push(CMD_CONVERT, 16'h1234);
    push(CMD_BEGIN, 16'h0000);
    push(CMD_CONVERT, 16'h0000);
    push(CMD_UNUSED, 16'hffff);
    push(CMD_CONVERT, 16'hffff);
    drain();

    // 1555, all-ones key: alpha bit ignored in compare
    cfg_write(CFG_SOURCE_FORMAT, CFG_DATA_W'(FMT_ARGB1555));
    cfg_write(CFG_CHROMA_KEY, 16'hffff);
    push(CMD_BEGIN, 16'h0000);
    push(CMD_SCAN, 16'h7fff);
    push(CMD_SCAN, 16'hffff);
    push(CMD_SCAN, 16'h8000);
    push(CMD_SCAN, 16'h1234);
    push(CMD_CONVERT, 16'hffff);
    push(CMD_CONVERT, 16'h7fff);
    push(CMD_CONVERT, 16'h0001);
    push(CMD_CONVERT, 16'h8001);
    push(CMD_CONVERT, 16'h7fff);
    push(CMD_UNUSED, 16'h7fff);
    push(CMD_SCAN, 16'h4210);
    push(CMD_CONVERT, 16'hffff);
    drain();

    // 565 with magenta key, one keyed scan and one unkeyed scan
    cfg_write(CFG_SOURCE_FORMAT, CFG_DATA_W'(FMT_RGB565));
    cfg_write(CFG_CHROMA_KEY, 16'hf81f);
    push(CMD_BEGIN, 16'hffff);
    push(CMD_SCAN, 16'hf81f);
    push(CMD_CONVERT, 16'hf81f);
    push(CMD_SCAN, 16'h07e0);
    push(CMD_CONVERT, 16'h07e0);
    push(CMD_CONVERT, 16'hf81f);
    drain();

    // random textures under changing settings
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      cfg_write(CFG_SOURCE_FORMAT, CFG_DATA_W'($urandom_range(0, 1)));
      case (phase % 4)
        0: cfg_write(CFG_CHROMA_KEY, 16'h0000);
        1: cfg_write(CFG_CHROMA_KEY, 16'hffff);
        default: cfg_write(CFG_CHROMA_KEY, 16'($urandom));
      endcase
      src_idle_en = (phase % 3) != 2;
      snk_idle_en = (phase % 3) != 2 && $urandom_range(0, 3) != 0;
      in_phase = 0;
      while (in_phase < 75) begin
        push_texture(n);
        in_phase += n;
      end
      sent += in_phase;
      drain();
      phase++;
    end

    errors += pixel_q.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
